/* sv/fdec_pkg.sv */
package fdec_pkg;

    localparam int CHANNELS    = 4;
    localparam int MAX_TAPS    = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(MAX_TAPS);
    localparam int TAP_BITS    = ADDR_BITS + 1;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + ADDR_BITS + 1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DECIM = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAPS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHIFT = 2'd2;

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic                 rd_live;
        logic                 mul_en;
        logic                 acc_en;
        logic                 acc_clr;
    } lane_ctrl_t;

endpackage

/* sv/fdec_in_if.sv */
interface fdec_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [6:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] sample_ch0;
    logic signed [15:0] sample_ch1;
    logic signed [15:0] sample_ch2;
    logic signed [15:0] sample_ch3;

    modport source (output valid, cmd, coef_index, coef_value,
                    sample_ch0, sample_ch1, sample_ch2, sample_ch3, input ready);
    modport sink   (input valid, cmd, coef_index, coef_value,
                    sample_ch0, sample_ch1, sample_ch2, sample_ch3, output ready);
endinterface

/* sv/fdec_out_if.sv */
interface fdec_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] filtered_ch0;
    logic signed [15:0] filtered_ch1;
    logic signed [15:0] filtered_ch2;
    logic signed [15:0] filtered_ch3;

    modport source (output valid, filtered_ch0, filtered_ch1, filtered_ch2,
                    filtered_ch3, input ready);
    modport sink   (input valid, filtered_ch0, filtered_ch1, filtered_ch2,
                    filtered_ch3, output ready);
endinterface

/* sv/fdec_lane.sv */
module fdec_lane
    import fdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lane_ctrl_t ctrl,
    input  sample_t    wr_data,
    input  coef_t      coef,
    output acc_t       acc
);

    sample_t mem [MAX_TAPS];
    sample_t samp_reg;
    logic    live_reg;
    prod_t   prod_reg;
    acc_t    acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            samp_reg <= mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= 1'b0;
        end
        else if (ctrl.rd_en)
        begin
            live_reg <= ctrl.rd_live;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= live_reg ? prod_t'(samp_reg * coef) : '0;
        end
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_reg + acc_t'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

/* sv/fdec_merge.sv */
module fdec_merge
    import fdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [4:0] shift,
    input  acc_t       acc [CHANNELS],
    output logic       free,
    fdec_out_if.source results
);

    localparam acc_t SAT_HI = acc_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam acc_t SAT_LO = -SAT_HI - acc_t'(1);

    logic    valid_reg;
    sample_t data_reg [CHANNELS];
    sample_t data_next [CHANNELS];
    acc_t    shifted [CHANNELS];

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            shifted[c] = acc[c] >>> shift;
            if (shifted[c] > SAT_HI)
            begin
                data_next[c] = sample_t'(SAT_HI);
            end
            else if (shifted[c] < SAT_LO)
            begin
                data_next[c] = sample_t'(SAT_LO);
            end
            else
            begin
                data_next[c] = shifted[c][SAMPLE_BITS-1:0];
            end
        end
    end

    assign free = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign results.valid        = valid_reg;
    assign results.filtered_ch0 = data_reg[0];
    assign results.filtered_ch1 = data_reg[1];
    assign results.filtered_ch2 = data_reg[2];
    assign results.filtered_ch3 = data_reg[3];

endmodule

/* sv/multichannel_fir_decimator.sv */
// Coefficient write or non-emitting sample set: accepted while idle, and ready stays high for the next item.
// Emitting sample set: one read per tap, taps being taps_used capped at 128, then the multiply and
// accumulate registers drain and the result is loaded into the output register once that is free;
// one multiply-accumulate per tap in each channel lane. Ready stays low until the result is loaded.
// A finished result waits in the output register while the next items are accepted.
// Reset clears control state and sets decimation 3, 98 taps, shift 15; delay lines read as zero through a fill count.
// The coefficient table is not cleared and must be written before use.
module multichannel_fir_decimator
    import fdec_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    fdec_in_if.sink                  samples,
    fdec_out_if.source               results
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [4:0]          decim_reg;
    logic [7:0]          taps_cfg_reg;
    logic [4:0]          shift_reg;
    logic [ADDR_BITS-1:0] wp_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic [3:0]          phase_reg;
    logic [TAP_BITS-1:0] fill_reg;
    logic [TAP_BITS-1:0] k_reg;
    logic [TAP_BITS-1:0] taps_reg;
    logic                mul_v_reg, acc_v_reg;
    coef_t               coef_mem [MAX_TAPS];
    coef_t               coef_q_reg;

    logic                accept, acc_coef, acc_samp, emit, iss, free, load;
    logic [4:0]          dec_eff;
    logic [TAP_BITS-1:0] taps_eff;
    lane_ctrl_t          ctrl;
    sample_t             samp_in [CHANNELS];
    acc_t                acc [CHANNELS];

    assign accept   = samples.valid && samples.ready;
    assign acc_coef = accept && samples.cmd == CMD_COEF;
    assign acc_samp = accept && samples.cmd == CMD_SAMPLE;
    assign emit     = acc_samp && phase_reg == 4'd0;
    assign samples.ready = state_reg == S_IDLE;
    assign iss      = state_reg == S_RUN && k_reg < taps_reg;
    assign load     = state_reg == S_FIN && free;

    assign dec_eff  = (decim_reg == 5'd0) ? 5'd1 : (decim_reg > 5'd16) ? 5'd16 : decim_reg;
    assign taps_eff = (taps_cfg_reg > 8'(MAX_TAPS)) ? TAP_BITS'(MAX_TAPS)
                                                    : TAP_BITS'(taps_cfg_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg    <= 5'd3;
            taps_cfg_reg <= 8'd98;
            shift_reg    <= 5'd15;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DECIM: decim_reg    <= cfg_data[4:0];
                CFG_TAPS:  taps_cfg_reg <= cfg_data;
                CFG_SHIFT: shift_reg    <= cfg_data[4:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (emit) state_next = S_RUN;
            S_RUN:   if (!iss) state_next = S_DRAIN;
            S_DRAIN: if (!mul_v_reg && !acc_v_reg) state_next = S_FIN;
            S_FIN:   if (free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            base_reg  <= '0;
            phase_reg <= '0;
            fill_reg  <= '0;
            k_reg     <= '0;
            taps_reg  <= '0;
            mul_v_reg <= 1'b0;
            acc_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mul_v_reg <= iss;
            acc_v_reg <= mul_v_reg;
            if (acc_samp)
            begin
                base_reg  <= wp_reg;
                wp_reg    <= wp_reg + 1'b1;
                phase_reg <= (5'(phase_reg) + 5'd1 >= dec_eff) ? 4'd0 : phase_reg + 4'd1;
                if (fill_reg != TAP_BITS'(MAX_TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (emit)
            begin
                k_reg    <= '0;
                taps_reg <= taps_eff;
            end
            else if (iss)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_coef)
        begin
            coef_mem[samples.coef_index[ADDR_BITS-1:0]] <= samples.coef_value;
        end
        if (iss)
        begin
            coef_q_reg <= coef_mem[k_reg[ADDR_BITS-1:0]];
        end
    end

    always_comb
    begin
        ctrl.wr_en   = acc_samp;
        ctrl.wr_addr = wp_reg;
        ctrl.rd_en   = iss;
        ctrl.rd_addr = base_reg - k_reg[ADDR_BITS-1:0];
        ctrl.rd_live = k_reg < fill_reg;
        ctrl.mul_en  = mul_v_reg;
        ctrl.acc_en  = acc_v_reg;
        ctrl.acc_clr = emit;
    end

    assign samp_in[0] = samples.sample_ch0;
    assign samp_in[1] = samples.sample_ch1;
    assign samp_in[2] = samples.sample_ch2;
    assign samp_in[3] = samples.sample_ch3;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        fdec_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .wr_data (samp_in[c]),
            .coef    (coef_q_reg),
            .acc     (acc[c])
        );
    end

    fdec_merge u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .shift   (shift_reg),
        .acc     (acc),
        .free    (free),
        .results (results)
    );

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        samples.ready |-> !mul_v_reg && !acc_v_reg)
        else $error("pipeline busy while accepting");

    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> k_reg <= taps_reg)
        else $error("tap counter overran");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= TAP_BITS'(MAX_TAPS))
        else $error("fill count overran");

    a_load_run: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> results.valid && state_reg == S_IDLE)
        else $error("result not presented");

endmodule
